FILE: rtl/pcdc_pkg.sv
// Shared constants, types and codes for the depth-image colorizer.
`timescale 1ns / 1ps
package pcdc_pkg;

    // image geometry
    localparam int IMG_WIDTH     = 384;
    localparam int IMG_HEIGHT    = 216;
    localparam int WINDOW_RADIUS = 7;
    localparam int HALF_W        = IMG_WIDTH / 2;
    localparam int HALF_H        = IMG_HEIGHT / 2;
    localparam int DEPTH         = IMG_WIDTH * IMG_HEIGHT;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int COL_W         = $clog2(IMG_WIDTH);
    localparam int ROW_W         = $clog2(IMG_HEIGHT);

    // port field widths
    localparam int OP_W      = 2;
    localparam int COORD_W   = 24;
    localparam int SCALE_W   = 24;
    localparam int PCOL_W    = 9;
    localparam int PROW_W    = 8;
    localparam int CH_W      = 8;
    localparam int CFG_IDX_W = 1;
    localparam int DV_W      = 16;

    localparam int SCALE_FRAC = 8;
    localparam int HSCALE_RST = 67633;
    localparam int VSCALE_RST = 68429;
    localparam int DEPTH_MAX  = 65535;

    // hole-fill window
    localparam int WIN_SPAN = 2 * WINDOW_RADIUS + 1;
    localparam int WIN_N    = WIN_SPAN * WIN_SPAN;
    localparam int OFF_W    = $clog2(WIN_SPAN);
    localparam int DSQ_MAX  = 2 * WINDOW_RADIUS * WINDOW_RADIUS;
    localparam int DSQ_W    = $clog2(DSQ_MAX + 1);
    localparam int WT_W     = 25;
    localparam int WT_ONE   = 1 << 24;
    localparam int TOP_W    = DV_W + WT_W + $clog2(WIN_N);
    localparam int BOT_W    = WT_W + $clog2(WIN_N);

    // shared multiplier, divider, square root
    localparam int MUL_W  = COORD_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_NW = (TOP_W > 2 * COORD_W) ? TOP_W : 2 * COORD_W;
    localparam int DIV_DW = (BOT_W > COORD_W + SCALE_FRAC) ? BOT_W : COORD_W + SCALE_FRAC;
    localparam int SQ_W   = 2 * COORD_W;
    localparam int ROOT_W = COORD_W;

    // hue map
    localparam int    SEG_SPAN = 10923;
    localparam int    CH_MAX   = 255;
    localparam int    SEG_HW   = $clog2(6 * SEG_SPAN + 1);
    localparam int    SEG_T_W  = $clog2(SEG_SPAN + 1);
    localparam int    RAMP_W   = $clog2(CH_MAX * SEG_SPAN + 1);
    localparam int    RECIP_SH = RAMP_W + $clog2(SEG_SPAN);
    localparam longint RECIP_VAL = ((64'd1 << RECIP_SH) + SEG_SPAN - 1) / SEG_SPAN;
    localparam int    RECIP_W  = $clog2(RECIP_VAL + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_HSCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VSCALE = 1'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_st;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

endpackage

FILE: rtl/pcdc_if.sv
// Handshake channel interfaces for point items and colour results.
`timescale 1ns / 1ps
interface pcdc_in_if import pcdc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [PCOL_W-1:0]         pixel_col;
    logic [PROW_W-1:0]         pixel_row;

    modport source (output valid, op, coord_x, coord_y, coord_z, pixel_col, pixel_row,
                    input ready);
    modport sink   (input valid, op, coord_x, coord_y, coord_z, pixel_col, pixel_row,
                    output ready);
endinterface

interface pcdc_out_if import pcdc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

FILE: rtl/point_cloud_depth_image_colorizer.sv
// Top level: depth store, point projection, hole-fill walk and result register.
//
//  channel   dir  handshake          payload
//  i_item    in   valid/ready        op, coord_x/y/z, pixel_col, pixel_row
//  o_result  out  valid/ready        red, green, blue (read pixel only)
//  i_cfg_*   in   write enable only  index 0 horizontal scale, 1 vertical scale
//
// One item at a time; i_item.ready is high only when the sequencer is idle.
// Add point: projection and depth through the bit-serial divider and root.
// Hole fill (read of an empty pixel): WIN_N window reads through the
// single memory read port plus one divide when any neighbour is set.
// Reset and the clear op sweep the depth store; no items are taken during the sweep.
// The result register frees the sequencer while o_result is stalled, unless a second result is ready first.
`timescale 1ns / 1ps
module point_cloud_depth_image_colorizer import pcdc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SCALE_W-1:0]   i_cfg_data,
    pcdc_in_if.sink              i_item,
    pcdc_out_if.source           o_result
);
    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_MULY  = 15'b000000000000100,
        S_DIVY  = 15'b000000000001000,
        S_MULZ  = 15'b000000000010000,
        S_DIVZ  = 15'b000000000100000,
        S_SQ    = 15'b000000001000000,
        S_SQRT  = 15'b000000010000000,
        S_RDC   = 15'b000000100000000,
        S_RDCW  = 15'b000001000000000,
        S_WIN   = 15'b000010000000000,
        S_DRAIN = 15'b000100000000000,
        S_HDIV  = 15'b001000000000000,
        S_COLOR = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } t_state;

    localparam int NC_W = COL_W + 2;
    localparam int NR_W = ROW_W + 2;

    t_state r_state, n_state;

    logic [SCALE_W-1:0]        r_hs, r_vs;
    logic signed [COORD_W-1:0] r_x, r_y, r_z;
    logic [COL_W-1:0]          r_pc, r_col;
    logic [ROW_W-1:0]          r_pr, r_row;
    logic                      r_col_ok;
    logic signed [PROD_W-1:0]  r_prod;
    logic [SQ_W-1:0]           r_sum;
    logic [1:0]                r_k;
    logic                      r_div_go, r_sqrt_go, r_col_go;
    logic [ADDR_W-1:0]         r_clr_addr;
    logic [OFF_W-1:0]          r_dx, r_dy;
    logic [1:0]                r_drain;
    logic                      r_p1_v, r_p2_v;
    logic [DSQ_W-1:0]          r_p1_dsq;
    logic [DV_W+WT_W-1:0]      r_p2_prod;
    logic [WT_W-1:0]           r_p2_w;
    logic [TOP_W-1:0]          r_top;
    logic [BOT_W-1:0]          r_bot;
    logic [DV_W-1:0]           r_hue;
    t_rgb                      r_res, r_out;
    logic                      r_out_v;
    logic [DV_W-1:0]           r_mem [0:DEPTH-1];
    logic [DV_W-1:0]           r_rdata;

    logic                      w_acc;
    logic [COORD_W-1:0]        w_ay;
    logic                      w_x_ok, w_in_img;
    logic signed [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [PROD_W-1:0]         w_mag;
    logic [DIV_NW-1:0]         w_div_num;
    logic [DIV_DW-1:0]         w_div_den;
    t_unit_st                  w_div_st, w_sqrt_st;
    logic [DIV_NW-1:0]         w_quo;
    logic                      w_rnz, w_neg;
    logic [DIV_NW:0]           w_qa, w_qz;
    logic                      w_col_ok, w_row_ok;
    logic [COL_W-1:0]          w_col;
    logic [ROW_W-1:0]          w_row;
    logic [ROOT_W-1:0]         w_root;
    logic [DV_W-1:0]           w_sat;
    logic signed [NC_W-1:0]    w_nc;
    logic signed [NR_W-1:0]    w_nr;
    logic signed [OFF_W:0]     w_ox, w_oy;
    logic [DSQ_W-1:0]          w_dsq;
    logic                      w_nb_in, w_last;
    logic [ADDR_W-1:0]         w_rd_addr, w_wr_addr;
    logic                      w_mem_we;
    logic [DV_W-1:0]           w_mem_wdata;
    logic                      w_col_done;
    t_rgb                      w_col_rgb;
    logic [WT_W-1:0]           w_wtab [0:DSQ_MAX];

    // inverse-square weights, one per squared distance
    for (genvar gi = 0; gi <= DSQ_MAX; gi++) begin : g_wt
        localparam int WV = (gi == 0) ? 0 : WT_ONE / ((gi == 0) ? 1 : gi);
        assign w_wtab[gi] = WT_W'(WV);
    end

    assign w_acc        = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        w_ay     = i_item.coord_y[COORD_W-1] ? COORD_W'(-i_item.coord_y)
                                             : COORD_W'(i_item.coord_y);
        w_x_ok   = (i_item.coord_x > 0) && (COORD_W'(i_item.coord_x) >= w_ay);
        w_in_img = (int'(i_item.pixel_col) < IMG_WIDTH)
                && (int'(i_item.pixel_row) < IMG_HEIGHT);
    end

    // shared multiplier operands; the product is held through each divide
    always_comb begin
        w_mul_a = {r_y[COORD_W-1], r_y};
        w_mul_b = $signed({1'b0, r_hs});
        if ((r_state == S_MULZ) || (r_state == S_DIVZ)) begin
            w_mul_a = {r_z[COORD_W-1], r_z};
            w_mul_b = $signed({1'b0, r_vs});
        end else if (r_state == S_SQ) begin
            case (r_k)
                2'd0:    w_mul_a = {r_x[COORD_W-1], r_x};
                2'd1:    w_mul_a = {r_y[COORD_W-1], r_y};
                default: w_mul_a = {r_z[COORD_W-1], r_z};
            endcase
            w_mul_b = w_mul_a;
        end
    end

    // divider operands and floor projection
    always_comb begin
        w_mag     = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        w_div_num = (r_state == S_HDIV) ? DIV_NW'(r_top) : DIV_NW'(w_mag);
        w_div_den = (r_state == S_HDIV) ? DIV_DW'(r_bot)
                                        : DIV_DW'({r_x, {SCALE_FRAC{1'b0}}});
        w_neg     = r_prod[PROD_W-1];
        w_qz      = {1'b0, w_quo};
        w_qa      = w_qz + (DIV_NW+1)'(w_rnz);
        w_col_ok  = w_neg ? (w_qa < (DIV_NW+1)'(IMG_WIDTH - HALF_W))
                          : (w_qz <= (DIV_NW+1)'(HALF_W));
        w_row_ok  = w_neg ? (w_qa < (DIV_NW+1)'(IMG_HEIGHT - HALF_H))
                          : (w_qz <= (DIV_NW+1)'(HALF_H));
        w_col     = w_neg ? COL_W'((DIV_NW+1)'(HALF_W) + w_qa)
                          : COL_W'((DIV_NW+1)'(HALF_W) - w_qz);
        w_row     = w_neg ? ROW_W'((DIV_NW+1)'(HALF_H) + w_qa)
                          : ROW_W'((DIV_NW+1)'(HALF_H) - w_qz);
        w_sat     = (|w_root[ROOT_W-1:DV_W]) ? DV_W'(DEPTH_MAX) : w_root[DV_W-1:0];
    end

    // window neighbour position
    always_comb begin
        w_nc    = $signed({2'b00, r_pc}) + $signed(NC_W'(r_dx)) - $signed(NC_W'(WINDOW_RADIUS));
        w_nr    = $signed({2'b00, r_pr}) + $signed(NR_W'(r_dy)) - $signed(NR_W'(WINDOW_RADIUS));
        w_ox    = $signed({1'b0, r_dx}) - $signed((OFF_W+1)'(WINDOW_RADIUS));
        w_oy    = $signed({1'b0, r_dy}) - $signed((OFF_W+1)'(WINDOW_RADIUS));
        w_dsq   = DSQ_W'(w_ox * w_ox) + DSQ_W'(w_oy * w_oy);
        w_nb_in = (w_nc >= 0) && (w_nc < $signed(NC_W'(IMG_WIDTH)))
               && (w_nr >= 0) && (w_nr < $signed(NR_W'(IMG_HEIGHT)));
        w_last  = (r_dx == OFF_W'(2 * WINDOW_RADIUS)) && (r_dy == OFF_W'(2 * WINDOW_RADIUS));
    end

    // memory port addressing
    always_comb begin
        w_rd_addr   = (r_state == S_RDC) ? ADDR_W'(r_pr * IMG_WIDTH + r_pc)
                    : ADDR_W'(w_nr[ROW_W-1:0] * IMG_WIDTH + w_nc[COL_W-1:0]);
        w_wr_addr   = (r_state == S_CLEAR) ? r_clr_addr
                    : ADDR_W'(r_row * IMG_WIDTH + r_col);
        w_mem_we    = (r_state == S_CLEAR) || ((r_state == S_SQRT) && w_sqrt_st.done);
        w_mem_wdata = (r_state == S_CLEAR) ? '0 : w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= w_mem_wdata;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == ADDR_W'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_item.op)
                        OP_ADD:   if (w_x_ok) n_state = S_MULY;
                        OP_READ:  n_state = w_in_img ? S_RDC : S_OUT;
                        OP_CLEAR: n_state = S_CLEAR;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_MULY:  n_state = S_DIVY;
            S_DIVY:  if (w_div_st.done) n_state = S_MULZ;
            S_MULZ:  n_state = S_DIVZ;
            S_DIVZ: begin
                if (w_div_st.done) n_state = (r_col_ok && w_row_ok) ? S_SQ : S_IDLE;
            end
            S_SQ:    if (r_k == 2'd3) n_state = S_SQRT;
            S_SQRT:  if (w_sqrt_st.done) n_state = S_IDLE;
            S_RDC:   n_state = S_RDCW;
            S_RDCW:  n_state = (r_rdata != '0) ? S_COLOR : S_WIN;
            S_WIN:   if (w_last) n_state = S_DRAIN;
            S_DRAIN: if (r_drain == 2'd2) n_state = (r_bot == '0) ? S_OUT : S_HDIV;
            S_HDIV:  if (w_div_st.done) n_state = S_COLOR;
            S_COLOR: if (w_col_done) n_state = S_OUT;
            S_OUT:   if (!r_out_v || o_result.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_hs       <= SCALE_W'(HSCALE_RST);
            r_vs       <= SCALE_W'(VSCALE_RST);
            r_div_go   <= 1'b0;
            r_sqrt_go  <= 1'b0;
            r_col_go   <= 1'b0;
            r_p1_v     <= 1'b0;
            r_p2_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_HSCALE: r_hs <= i_cfg_data;
                    REG_VSCALE: r_vs <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end else begin
                r_clr_addr <= '0;
            end
            r_div_go  <= (r_state == S_MULY) || (r_state == S_MULZ)
                      || ((r_state == S_DRAIN) && (r_drain == 2'd2) && (r_bot != '0));
            r_sqrt_go <= (r_state == S_SQ) && (r_k == 2'd3);
            r_col_go  <= ((r_state == S_RDCW) && (r_rdata != '0))
                      || ((r_state == S_HDIV) && w_div_st.done);
            r_p1_v    <= (r_state == S_WIN) && w_nb_in;
            r_p2_v    <= r_p1_v && (r_rdata != '0);
            if ((r_state == S_OUT) && (!r_out_v || o_result.ready)) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && o_result.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (w_acc) begin
            r_x  <= i_item.coord_x;
            r_y  <= i_item.coord_y;
            r_z  <= i_item.coord_z;
            r_pc <= COL_W'(i_item.pixel_col);
            r_pr <= ROW_W'(i_item.pixel_row);
            r_res <= '0;
        end
        if ((r_state == S_DIVY) && w_div_st.done) begin
            r_col_ok <= w_col_ok;
            r_col    <= w_col;
        end
        if ((r_state == S_DIVZ) && w_div_st.done) begin
            r_row <= w_row;
            r_k   <= '0;
            r_sum <= '0;
        end
        if (r_state == S_SQ) begin
            r_k <= r_k + 1'b1;
            if (r_k != 2'd0) r_sum <= r_sum + SQ_W'(r_prod);
        end
        // window walk, column-major
        if (r_state == S_RDCW) begin
            r_dx  <= '0;
            r_dy  <= '0;
            r_top <= '0;
            r_bot <= '0;
            r_hue <= r_rdata;
        end
        if (r_state == S_WIN) begin
            r_drain <= '0;
            if (r_dy == OFF_W'(2 * WINDOW_RADIUS)) begin
                r_dy <= '0;
                r_dx <= r_dx + 1'b1;
            end else begin
                r_dy <= r_dy + 1'b1;
            end
        end
        if (r_state == S_DRAIN) begin
            r_drain <= r_drain + 1'b1;
            if (r_drain == 2'd2) r_res <= '0;
        end
        r_p1_dsq  <= w_dsq;
        r_p2_w    <= w_wtab[r_p1_dsq];
        r_p2_prod <= r_rdata * w_wtab[r_p1_dsq];
        if (r_p2_v) begin
            r_top <= r_top + TOP_W'(r_p2_prod);
            r_bot <= r_bot + BOT_W'(r_p2_w);
        end
        if ((r_state == S_HDIV) && w_div_st.done) begin
            r_hue <= w_quo[DV_W-1:0];
        end
        if ((r_state == S_COLOR) && w_col_done) begin
            r_res <= w_col_rgb;
        end
        if ((r_state == S_OUT) && (!r_out_v || o_result.ready)) begin
            r_out <= r_res;
        end
    end

    pcdc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_div_go),
        .i_num    (w_div_num),
        .i_den    (w_div_den),
        .o_st     (w_div_st),
        .o_quo    (w_quo),
        .o_rem_nz (w_rnz)
    );

    pcdc_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_go),
        .i_val   (r_sum),
        .o_st    (w_sqrt_st),
        .o_root  (w_root)
    );

    pcdc_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_col_go),
        .i_hue   (r_hue),
        .o_done  (w_col_done),
        .o_rgb   (w_col_rgb)
    );

    assign o_result.valid = r_out_v;
    assign o_result.red   = r_out.red;
    assign o_result.green = r_out.green;
    assign o_result.blue  = r_out.blue;

    a_mem_we_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == S_CLEAR || r_state == S_SQRT))
        else $error("depth store written outside clear sweep or point write");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (w_mem_wdata == '0))
        else $error("clear sweep writes nonzero depth");

    a_walk_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_v |-> (r_state == S_WIN || r_state == S_DRAIN))
        else $error("window accumulate outside the walk");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> !w_div_st.busy)
        else $error("divider started while busy");
endmodule

FILE: rtl/pcdc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pcdc_div import pcdc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output t_unit_st          o_st,
    output logic [DIV_NW-1:0] o_quo,
    output logic              o_rem_nz
);
    localparam int CNT_W = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   w_rem_sh;
    logic              w_ge;
    logic [DIV_DW-1:0] n_rem;

    always_comb begin
        w_rem_sh = {r_rem, r_num[DIV_NW-1]};
        w_ge     = w_rem_sh >= {1'b0, r_den};
        n_rem    = w_ge ? DIV_DW'(w_rem_sh - {1'b0, r_den}) : DIV_DW'(w_rem_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                // quotient bits shift in behind the dividend bits
                r_num <= {r_num[DIV_NW-2:0], w_ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_done;
    assign o_quo     = r_num;
    assign o_rem_nz  = |r_rem;
endmodule

FILE: rtl/pcdc_isqrt.sv
// Integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module pcdc_isqrt import pcdc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_val,
    output t_unit_st          o_st,
    output logic [ROOT_W-1:0] o_root
);
    localparam int CNT_W = $clog2(ROOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SQ_W-1:0]   r_val;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+3:0] w_rem_sh;
    logic [ROOT_W+3:0] w_trial;
    logic              w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_val[SQ_W-1 -: 2]};
        w_trial  = (ROOT_W+4)'({r_root, 2'b01});
        w_ge     = w_rem_sh >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val  <= {r_val[SQ_W-3:0], 2'b00};
                r_rem  <= w_ge ? (ROOT_W+2)'(w_rem_sh - w_trial) : (ROOT_W+2)'(w_rem_sh);
                r_root <= {r_root[ROOT_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_done;
    assign o_root    = r_root;
endmodule

FILE: rtl/pcdc_color.sv
// Six-segment hue to RGB map, four pipeline stages.
`timescale 1ns / 1ps
module pcdc_color import pcdc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DV_W-1:0] i_hue,
    output logic            o_done,
    output t_rgb            o_rgb
);
    typedef enum logic [2:0] {
        SG_RISE_G = 3'd0,
        SG_FALL_R = 3'd1,
        SG_RISE_B = 3'd2,
        SG_FALL_G = 3'd3,
        SG_RISE_R = 3'd4,
        SG_FALL_B = 3'd5
    } t_seg;

    logic                        r_v1, r_v2, r_v3, r_v4;
    t_seg                        r_seg1, r_seg2, r_seg3;
    logic [SEG_T_W-1:0]          r_t;
    logic [RAMP_W-1:0]           r_num;
    logic [RAMP_W+RECIP_W-1:0]   r_prod;
    t_rgb                        r_rgb;
    logic [SEG_HW-1:0]           w_h;
    t_seg                        w_seg;
    logic [SEG_HW-1:0]           w_t;
    logic [CH_W-1:0]             w_ramp;

    always_comb begin
        w_h = SEG_HW'(i_hue);
        if (w_h < SEG_HW'(SEG_SPAN)) begin
            w_seg = SG_RISE_G;  w_t = w_h;
        end else if (w_h < SEG_HW'(2 * SEG_SPAN)) begin
            w_seg = SG_FALL_R;  w_t = SEG_HW'(2 * SEG_SPAN) - w_h;
        end else if (w_h < SEG_HW'(3 * SEG_SPAN)) begin
            w_seg = SG_RISE_B;  w_t = w_h - SEG_HW'(2 * SEG_SPAN);
        end else if (w_h < SEG_HW'(4 * SEG_SPAN)) begin
            w_seg = SG_FALL_G;  w_t = SEG_HW'(4 * SEG_SPAN) - w_h;
        end else if (w_h < SEG_HW'(5 * SEG_SPAN)) begin
            w_seg = SG_RISE_R;  w_t = w_h - SEG_HW'(4 * SEG_SPAN);
        end else begin
            w_seg = SG_FALL_B;
            w_t   = (w_h < SEG_HW'(6 * SEG_SPAN)) ? SEG_HW'(6 * SEG_SPAN) - w_h : '0;
        end
        // floor(num / SEG_SPAN) through the reciprocal
        w_ramp = CH_W'(r_prod >> RECIP_SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_seg1 <= w_seg;
        r_t    <= SEG_T_W'(w_t);
        r_seg2 <= r_seg1;
        r_num  <= RAMP_W'(CH_MAX * r_t);
        r_seg3 <= r_seg2;
        r_prod <= r_num * RECIP_W'(RECIP_VAL);
        case (r_seg3)
            SG_RISE_G: r_rgb <= '{CH_W'(CH_MAX), w_ramp, '0};
            SG_FALL_R: r_rgb <= '{w_ramp, CH_W'(CH_MAX), '0};
            SG_RISE_B: r_rgb <= '{'0, CH_W'(CH_MAX), w_ramp};
            SG_FALL_G: r_rgb <= '{'0, w_ramp, CH_W'(CH_MAX)};
            SG_RISE_R: r_rgb <= '{w_ramp, '0, CH_W'(CH_MAX)};
            SG_FALL_B: r_rgb <= '{CH_W'(CH_MAX), '0, w_ramp};
            default:   r_rgb <= '0;
        endcase
    end

    assign o_done = r_v4;
    assign o_rgb  = r_rgb;
endmodule

FILE: tb/tb_point_cloud_depth_image_colorizer.sv
// Self-checking testbench for the point-cloud depth-image colorizer.
`timescale 1ns / 1ps
module tb_point_cloud_depth_image_colorizer;
    import pcdc_pkg::*;

    localparam int MAX_CYCLES = 40_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [SCALE_W-1:0] i_cfg_data = '0;

    pcdc_in_if  item_ch ();
    pcdc_out_if rgb_ch ();

    point_cloud_depth_image_colorizer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch.sink),
        .o_result   (rgb_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [15:0] depth_img [0:DEPTH-1];
    logic [23:0] hscale, vscale;
    t_rgb expected_rgb [$];
    int n_fail = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_cnt = 0;

    function automatic logic [31:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic longint floor_quot(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic t_rgb hue_to_rgb(input longint h);
        longint r, g, b;
        if (h < SEG_SPAN) begin
            r = 255; g = 255 * h / SEG_SPAN; b = 0;
        end else if (h < 2 * SEG_SPAN) begin
            r = 255 * (2 * SEG_SPAN - h) / SEG_SPAN; g = 255; b = 0;
        end else if (h < 3 * SEG_SPAN) begin
            r = 0; g = 255; b = 255 * (h - 2 * SEG_SPAN) / SEG_SPAN;
        end else if (h < 4 * SEG_SPAN) begin
            r = 0; g = 255 * (4 * SEG_SPAN - h) / SEG_SPAN; b = 255;
        end else if (h < 5 * SEG_SPAN) begin
            r = 255 * (h - 4 * SEG_SPAN) / SEG_SPAN; g = 0; b = 255;
        end else begin
            r = 255; g = 0;
            b = (h < 6 * SEG_SPAN) ? 255 * (6 * SEG_SPAN - h) / SEG_SPAN : 0;
        end
        return '{red: r[7:0], green: g[7:0], blue: b[7:0]};
    endfunction

    task automatic project_point(input logic signed [23:0] x, input logic signed [23:0] y,
                                 input logic signed [23:0] z);
        longint lx, ly, lz, ay, col, row;
        logic [63:0] sq;
        logic [31:0] d;
        lx = x; ly = y; lz = z;
        ay = ly < 0 ? -ly : ly;
        if (lx <= 0 || lx < ay) return;
        col = HALF_W - floor_quot(ly * longint'(hscale), lx * 256);
        row = HALF_H - floor_quot(lz * longint'(vscale), lx * 256);
        if (col < 0 || col >= IMG_WIDTH || row < 0 || row >= IMG_HEIGHT) return;
        sq = lx * lx + ly * ly + lz * lz;
        d = int_sqrt(sq);
        if (d > DEPTH_MAX) d = DEPTH_MAX;
        depth_img[col + row * IMG_WIDTH] = d[15:0];
    endtask

    function automatic t_rgb pixel_colour(input int c, input int r);
        longint top, bottom, w;
        int nc, nr;
        logic [15:0] nv;
        if (c >= IMG_WIDTH || r >= IMG_HEIGHT) return '0;
        if (depth_img[c + r * IMG_WIDTH] != 0) return hue_to_rgb(depth_img[c + r * IMG_WIDTH]);
        top = 0; bottom = 0;
        for (int dx = -WINDOW_RADIUS; dx <= WINDOW_RADIUS; dx++)
            for (int dy = -WINDOW_RADIUS; dy <= WINDOW_RADIUS; dy++) begin
                nc = c + dx; nr = r + dy;
                if (nc < 0 || nc >= IMG_WIDTH || nr < 0 || nr >= IMG_HEIGHT) continue;
                nv = depth_img[nc + nr * IMG_WIDTH];
                if (nv == 0) continue;
                w = (longint'(1) << 24) / (dx * dx + dy * dy);
                top += longint'(nv) * w;
                bottom += w;
            end
        if (bottom == 0) return '0;
        return hue_to_rgb(top / bottom);
    endfunction

    // send one transaction and update the prediction on acceptance;
    // valid stays high afterwards so the next transaction can follow directly
    task automatic send_item(input t_op op, input logic [23:0] x, input logic [23:0] y,
                             input logic [23:0] z, input logic [8:0] pc, input logic [7:0] pr);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.op <= op;
        item_ch.coord_x <= x; item_ch.coord_y <= y; item_ch.coord_z <= z;
        item_ch.pixel_col <= pc; item_ch.pixel_row <= pr;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        case (op)
            OP_ADD:   project_point(x, y, z);
            OP_READ:  expected_rgb.push_back(pixel_colour(pc, pr));
            OP_CLEAR: foreach (depth_img[i]) depth_img[i] = '0;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // wait for outstanding results, then let a trailing add or clear drain
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (expected_rgb.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        while (!item_ch.ready) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_HSCALE) hscale = val; else vscale = val;
    endtask

    always @(posedge i_clk) begin
        t_rgb got, exp_v;
        if (rgb_ch.valid && rgb_ch.ready) begin
            got = '{red: rgb_ch.red, green: rgb_ch.green, blue: rgb_ch.blue};
            if (expected_rgb.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                n_fail++;
            end else begin
                exp_v = expected_rgb.pop_front();
                if (got !== exp_v) begin
                    $display("%0t: rgb mismatch expected %h actual %h", $time, exp_v, got);
                    n_fail++;
                end
            end
        end
    end

    always @(negedge i_clk)
        rgb_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [23:0] rnd24();
        return 24'($urandom());
    endfunction

    // point that lands inside the image at the reset scales
    task automatic add_visible();
        int x;
        x = $urandom_range(1000, 200000);
        send_item(OP_ADD, 24'(x), 24'($signed($urandom_range(0, 2 * x / 8)) - x / 8),
                  24'($signed($urandom_range(0, 2 * x / 8)) - x / 8), 0, 0);
    endtask

    task automatic test_directed();
        send_item(OP_READ, 0, 0, 0, 0, 0);               // empty image reads black
        send_item(OP_ADD, 24'd1000, 0, 0, 0, 0);         // center pixel
        send_item(OP_READ, 0, 0, 0, 9'(HALF_W), 8'(HALF_H));
        send_item(OP_READ, 0, 0, 0, 9'(HALF_W + 3), 8'(HALF_H - 2));  // hole fill
        send_item(OP_ADD, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 0);   // x equal to y, lands outside the image
        send_item(OP_ADD, 0, 0, 0, 0, 0);                // x zero dropped
        send_item(OP_ADD, 24'h800000, 0, 0, 0, 0);       // negative x dropped
        send_item(OP_ADD, 100, 101, 0, 0, 0);            // x below |y| dropped
        send_item(OP_ADD, 100, 24'hFFFF9C, 24'h7FFFFF, 0, 0);
        send_item(OP_ADD, 24'h7FFFFF, 24'h800001, 24'h800000, 0, 0);
        send_item(OP_READ, 0, 0, 0, 9'h1FF, 8'hFF);      // outside image
        send_item(OP_READ, 0, 0, 0, 9'd383, 8'd215);
        send_item(OP_READ, 0, 0, 0, 9'd384, 8'd0);
        send_item(OP_READ, 0, 0, 0, 9'd0, 8'd216);
        send_item(OP_NONE, rnd24(), rnd24(), rnd24(), 9'h1FF, 8'hFF);
        send_item(OP_READ, 0, 0, 0, 9'(HALF_W + 40), 8'(HALF_H));     // no neighbors
        send_item(OP_CLEAR, 0, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 9'(HALF_W), 8'(HALF_H));
        drain();
    endtask

    // random mix of clears, no-ops, adds and reads, most reads near the image centre
    task automatic test_random(input int n_items);
        int c, r;
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(19))
                0: send_item(OP_CLEAR, rnd24(), rnd24(), rnd24(), 9'($urandom), 8'($urandom));
                1: send_item(OP_NONE, rnd24(), rnd24(), rnd24(), 9'($urandom), 8'($urandom));
                2, 3: send_item(OP_ADD, rnd24(), rnd24(), rnd24(), 0, 0);
                4, 5, 6, 7, 8, 9: add_visible();
                10: send_item(OP_READ, 0, 0, 0, 9'($urandom), 8'($urandom));
                default: begin
                    c = HALF_W + $signed($urandom_range(0, 60)) - 30;
                    r = HALF_H + $signed($urandom_range(0, 40)) - 20;
                    send_item(OP_READ, rnd24(), rnd24(), rnd24(), 9'(c), 8'(r));
                end
            endcase
        end
    endtask

    task automatic test_scales();
        logic [23:0] hs [4] = '{24'd0, 24'hFFFFFF, 24'd256, HSCALE_RST};
        logic [23:0] vs [4] = '{24'hFFFFFF, 24'd0, 24'd20000, VSCALE_RST};
        for (int k = 0; k < 4; k++) begin
            write_reg(REG_HSCALE, hs[k]);
            write_reg(REG_VSCALE, vs[k]);
            send_item(OP_ADD, 24'd5000, 24'd30, 24'hFFFFE0, 0, 0);
            send_item(OP_ADD, 24'd5000, 24'hFFFFF0, 24'd17, 0, 0);
            send_item(OP_ADD, 24'd900, 24'd1, 24'd1, 0, 0);
            test_random(40);
            drain();
        end
    endtask

    initial begin
        int idle_pct [4] = '{0, 52, 0, 10};
        int stall_pct [4] = '{0, 0, 52, 10};
        item_ch.valid = 1'b0; item_ch.op = OP_NONE;
        item_ch.coord_x = '0; item_ch.coord_y = '0; item_ch.coord_z = '0;
        item_ch.pixel_col = '0; item_ch.pixel_row = '0;
        rgb_ch.ready = 1'b0;
        hscale = HSCALE_RST; vscale = VSCALE_RST;
        foreach (depth_img[i]) depth_img[i] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_scales();
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            test_random(270);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
